>>> design/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg: shared types and constants for the mono playback FIFO
// Event codes, sample width, register reset value and the per-beat
// status bundle that travels from the core to the output stage.
// ----------------------------------------------------------------------------
package mpf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 15;
	localparam int CNT_W    = 32;

	// Event codes carried on the func field.
	localparam logic [2:0] FN_MON_PUSH  = 3'd0;
	localparam logic [2:0] FN_WAV_PUSH  = 3'd1;
	localparam logic [2:0] FN_PULL      = 3'd2;
	localparam logic [2:0] FN_MON_ON    = 3'd3;
	localparam logic [2:0] FN_MON_OFF   = 3'd4;
	localparam logic [2:0] FN_WAV_START = 3'd5;
	localparam logic [2:0] FN_WAV_STOP  = 3'd6;

	// Reset value of the monitor prefill register.
	localparam logic [LEVEL_W-1:0] PREFILL_RESET = 15'd512;

	// Status and sample for one result beat.
	typedef struct packed {
		logic                       accepted;
		logic signed [SAMPLE_W-1:0] sample;
		logic [LEVEL_W-1:0]         fill_level;
		logic [CNT_W-1:0]           underrun_count;
		logic [CNT_W-1:0]           halves_count;
		logic                       streaming;
		logic                       monitor;
		logic                       wav;
		logic                       drained;
	} result_t;

endpackage

>>> design/mpf_ram.sv
// ----------------------------------------------------------------------------
// mpf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module mpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/mpf_core.sv
// ----------------------------------------------------------------------------
// mpf_core: ring state, session control and half-frame accounting
// Applies one event per advance and presents the post-event status.
// ----------------------------------------------------------------------------
module mpf_core #(
	parameter int RING_DEPTH  = 16384,
	parameter int HALF_FRAMES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic [2:0]                         func,
	input  logic signed [mpf_pkg::SAMPLE_W-1:0] sample,
	input  logic                               cfg_we,
	input  logic [mpf_pkg::LEVEL_W-1:0]        cfg_wdata,
	output mpf_pkg::result_t                   result
);

	import mpf_pkg::*;

	localparam int SPAN = 2 * RING_DEPTH;
	localparam int PW   = $clog2(SPAN);
	localparam int AW   = $clog2(RING_DEPTH);
	localparam int LW   = $clog2(RING_DEPTH + 1);
	localparam int FW   = (HALF_FRAMES > 1) ? $clog2(HALF_FRAMES) : 1;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
		return (p >= PW'(RING_DEPTH)) ? AW'(p - PW'(RING_DEPTH)) : AW'(p);
	endfunction

	function automatic logic [LW-1:0] count_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
		logic [PW:0] d;
		if (w >= r) begin
			d = {1'b0, w} - {1'b0, r};
		end else begin
			d = {1'b0, w} + (PW + 1)'(SPAN) - {1'b0, r};
		end
		return LW'(d);
	endfunction

	// State registers.
	logic [PW-1:0]       wp_q, rp_q;
	logic [LW-1:0]       cr_q;
	logic [FW-1:0]       pos_q;
	logic                starved_q, took_q, src_q;
	logic                mon_q, wav_q, run_q;
	logic [CNT_W-1:0]    und_q, hlv_q;
	logic [LEVEL_W-1:0]  prefill_q;
	logic                fwd_q;
	logic [SAMPLE_W-1:0] fwd_data_q;

	// Next-state values.
	logic [PW-1:0]       wp_n, rp_n;
	logic [LW-1:0]       cr_n;
	logic [FW-1:0]       pos_n;
	logic                starved_n, took_n, src_n;
	logic                mon_n, wav_n, run_n;
	logic [CNT_W-1:0]    und_n, hlv_n;

	logic                src_v, took_v;
	logic                acc;
	logic [SAMPLE_W-1:0] val;
	logic                ram_we;
	logic [AW-1:0]       wslot, rslot_n;
	logic [SAMPLE_W-1:0] ram_rdata, rd_data;
	logic [LW:0]         lvl_cur, lvl_nxt;
	logic                full_cur;
	logic [LEVEL_W:0]    pf_round;
	logic [31:0]         pf32, lvl32;
	logic [LW-1:0]       pf_credit;

	// Prefill rounded up to a multiple of 64, then capped at the ring depth.
	assign pf_round  = {1'b0, prefill_q} + (LEVEL_W + 1)'(63);
	assign pf32      = 32'({pf_round[LEVEL_W:6], 6'b0});
	assign pf_credit = (pf32 > 32'(RING_DEPTH)) ? LW'(RING_DEPTH) : LW'(pf32);

	assign lvl_cur  = {1'b0, count_of(wp_q, rp_q)} + {1'b0, cr_q};
	assign full_cur = (lvl_cur >= (LW + 1)'(RING_DEPTH));
	assign lvl_nxt  = {1'b0, count_of(wp_n, rp_n)} + {1'b0, cr_n};
	assign lvl32    = 32'(lvl_nxt);

	// The read port always looks at the next read pointer, so the head
	// sample is ready when the following pull arrives. A write landing on
	// that slot in the same cycle is forwarded.
	assign wslot   = slot_of(wp_q);
	assign rslot_n = slot_of(rp_n);
	assign rd_data = fwd_q ? fwd_data_q : ram_rdata;

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		cr_n      = cr_q;
		pos_n     = pos_q;
		starved_n = starved_q;
		took_n    = took_q;
		src_n     = src_q;
		mon_n     = mon_q;
		wav_n     = wav_q;
		run_n     = run_q;
		und_n     = und_q;
		hlv_n     = hlv_q;
		src_v     = src_q;
		took_v    = took_q;
		acc       = 1'b0;
		val       = '0;
		ram_we    = 1'b0;
		if (advance) begin
			unique case (func)
				FN_MON_PUSH: begin
					if (mon_q && !wav_q && run_q && !full_cur) begin
						ram_we = 1'b1;
						acc    = 1'b1;
						wp_n   = ptr_inc(wp_q);
					end
				end
				FN_WAV_PUSH: begin
					if (wav_q && !full_cur) begin
						ram_we = 1'b1;
						acc    = 1'b1;
						wp_n   = ptr_inc(wp_q);
					end
				end
				FN_PULL: begin
					if (run_q) begin
						src_v = (pos_q == '0) ? (wav_q || mon_q) : src_q;
						if (!starved_q && lvl_cur != '0) begin
							if (cr_q != '0) begin
								cr_n = cr_q - LW'(1);
							end else begin
								val  = rd_data;
								rp_n = ptr_inc(rp_q);
							end
							took_v = 1'b1;
						end else begin
							starved_n = 1'b1;
						end
						src_n  = src_v;
						took_n = took_v;
						if (pos_q == FW'(HALF_FRAMES - 1)) begin
							if (!took_v && src_v) begin
								und_n = und_q + CNT_W'(1);
							end
							hlv_n     = hlv_q + CNT_W'(1);
							pos_n     = '0;
							starved_n = 1'b0;
							took_n    = 1'b0;
							src_n     = 1'b0;
						end else begin
							pos_n = pos_q + FW'(1);
						end
					end
				end
				FN_MON_ON: begin
					if (!mon_q && !wav_q) begin
						wp_n = '0;
						rp_n = '0;
						cr_n = pf_credit;
					end
					mon_n = 1'b1;
					if (!run_q) begin
						hlv_n     = '0;
						pos_n     = '0;
						starved_n = 1'b0;
						took_n    = 1'b0;
						src_n     = 1'b0;
						run_n     = 1'b1;
					end
				end
				FN_MON_OFF: begin
					mon_n = 1'b0;
					if (run_q && !wav_q) begin
						run_n     = 1'b0;
						pos_n     = '0;
						starved_n = 1'b0;
						took_n    = 1'b0;
						src_n     = 1'b0;
						wp_n      = '0;
						rp_n      = '0;
						cr_n      = '0;
					end
				end
				FN_WAV_START: begin
					wav_n = 1'b1;
					wp_n  = '0;
					rp_n  = '0;
					cr_n  = '0;
					und_n = '0;
					if (!run_q) begin
						hlv_n     = '0;
						pos_n     = '0;
						starved_n = 1'b0;
						took_n    = 1'b0;
						src_n     = 1'b0;
						run_n     = 1'b1;
					end
				end
				FN_WAV_STOP: begin
					wav_n = 1'b0;
					if (mon_q) begin
						wp_n = '0;
						rp_n = '0;
						cr_n = '0;
					end else if (run_q) begin
						run_n     = 1'b0;
						pos_n     = '0;
						starved_n = 1'b0;
						took_n    = 1'b0;
						src_n     = 1'b0;
						wp_n      = '0;
						rp_n      = '0;
						cr_n      = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			cr_q      <= '0;
			pos_q     <= '0;
			starved_q <= 1'b0;
			took_q    <= 1'b0;
			src_q     <= 1'b0;
			mon_q     <= 1'b0;
			wav_q     <= 1'b0;
			run_q     <= 1'b0;
			und_q     <= '0;
			hlv_q     <= '0;
			prefill_q <= PREFILL_RESET;
			fwd_q     <= 1'b0;
		end else begin
			wp_q      <= wp_n;
			rp_q      <= rp_n;
			cr_q      <= cr_n;
			pos_q     <= pos_n;
			starved_q <= starved_n;
			took_q    <= took_n;
			src_q     <= src_n;
			mon_q     <= mon_n;
			wav_q     <= wav_n;
			run_q     <= run_n;
			und_q     <= und_n;
			hlv_q     <= hlv_n;
			fwd_q     <= ram_we && (wslot == rslot_n);
			if (cfg_we) begin
				prefill_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= sample;
	end

	mpf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wslot),
		.wdata (sample),
		.raddr (rslot_n),
		.rdata (ram_rdata)
	);

	always_comb begin
		result.accepted       = acc;
		result.sample         = val;
		result.fill_level     = lvl32[LEVEL_W-1:0];
		result.underrun_count = und_n;
		result.halves_count   = hlv_n;
		result.streaming      = run_n;
		result.monitor        = mon_n;
		result.wav            = wav_n;
		result.drained        = (lvl_nxt == '0);
	end

endmodule

>>> design/mono_playback_fifo_underrun_fill.sv
// ----------------------------------------------------------------------------
// mono_playback_fifo_underrun_fill: mono sample ring feeding a stereo stream
// Each input beat is one event (push, frame pull or session command); each
// produces exactly one result beat with the pulled frame and the status.
// Both channels use valid/ready. A beat lands in the input register, is
// applied to the ring state once the result register is free, and waits
// in the result register; one beat per cycle is sustained while the
// receiver keeps out_ready high, because the input register refills while
// the result register drains. The ring is a RAM whose read port is kept
// aimed at the head slot, so a pull need not wait for a RAM read.
// When the receiver stalls, the result register holds and the input
// register fills; ready drops only when both are full. Reset clears
// pointers, flags and counters and loads 512 into the prefill register;
// ring contents are left as they are since no slot is read before it is
// written.
// The monitor prefill register is written through cfg_we/cfg_wdata.
// ----------------------------------------------------------------------------
module mono_playback_fifo_underrun_fill #(
	parameter int RING_DEPTH  = 16384,
	parameter int HALF_FRAMES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          func,
	input  logic signed [mpf_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                accepted,
	output logic signed [mpf_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [mpf_pkg::SAMPLE_W-1:0] right_out,
	output logic [mpf_pkg::LEVEL_W-1:0]         fill_level,
	output logic [mpf_pkg::CNT_W-1:0]           underrun_count,
	output logic [mpf_pkg::CNT_W-1:0]           halves_count,
	output logic                                streaming_flag,
	output logic                                monitor_flag,
	output logic                                wav_flag,
	output logic                                drained,
	input  logic                                cfg_we,
	input  logic [mpf_pkg::LEVEL_W-1:0]         cfg_wdata
);

	import mpf_pkg::*;

	logic                       valid_s1;
	logic [2:0]                 func_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       valid_s2;
	result_t                    res_s2;
	result_t                    res;
	logic                       advance;

	// The event in the input register is applied when the result register
	// is empty or is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1   <= func;
			sample_s1 <= sample;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	mpf_core #(
		.RING_DEPTH  (RING_DEPTH),
		.HALF_FRAMES (HALF_FRAMES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.func      (func_s1),
		.sample    (sample_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (res)
	);

	// The mono sample goes to both slots of the frame.
	assign out_valid      = valid_s2;
	assign accepted       = res_s2.accepted;
	assign left_out       = res_s2.sample;
	assign right_out      = res_s2.sample;
	assign fill_level     = res_s2.fill_level;
	assign underrun_count = res_s2.underrun_count;
	assign halves_count   = res_s2.halves_count;
	assign streaming_flag = res_s2.streaming;
	assign monitor_flag   = res_s2.monitor;
	assign wav_flag       = res_s2.wav;
	assign drained        = res_s2.drained;

endmodule

>>> design/mpf_checker.sv
// ----------------------------------------------------------------------------
// mpf_checker: port-level checks for the mono playback FIFO
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mpf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                accepted,
	input logic signed [mpf_pkg::SAMPLE_W-1:0] left_out,
	input logic signed [mpf_pkg::SAMPLE_W-1:0] right_out,
	input logic                                streaming_flag,
	input logic                                monitor_flag,
	input logic                                wav_flag,
	input logic                                drained
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	// Both slots of a frame carry the same mono sample.
	a_stereo_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_out == right_out)
		else $error("left and right slots differ");

	// A stored push leaves at least one sample in the ring.
	a_push_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> !drained)
		else $error("push accepted but ring reports drained");

	// With the stream stopped no source owns the sink and frames are silent.
	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !streaming_flag |-> !monitor_flag && !wav_flag && left_out == '0)
		else $error("source active or audio present while stream stopped");

endmodule

bind mono_playback_fifo_underrun_fill mpf_checker u_mpf_checker (.*);
